@@ design/sfl_pkg.sv @@
// Shared constants for the lagged spectral flux block.
`timescale 1ns / 1ps

package sfl_pkg;

    localparam int DEF_MAX_BINS  = 1024;
    localparam int DEF_MAX_LAG   = 8;
    localparam int DEF_MAG_WIDTH = 16;

    // flux result width and its saturation value
    localparam int FLUX_W = 26;
    localparam logic [FLUX_W-1:0] FLUX_MAX = '1;

    // width of the frame_lag register
    localparam int LAG_CFG_W = 4;
    localparam logic [LAG_CFG_W-1:0] LAG_RESET = LAG_CFG_W'(1);

endpackage

@@ design/spectral_flux_lagged_top.sv @@
// Top level of the lagged spectral flux (L1) block with its history memory.
// Registers: rd_data_reg and p1_*, then m_flux_reg for a last bin. While not stalled,
// throughput is one magnitude per cycle; the history memory takes one read per request
// and, when in range, one write; the accumulator folds one absolute difference per cycle.
// Reset (aresetn low, synchronous): control state, counters, frame_lag (back to 1)
// and the accumulator are cleared; the history memory is not cleared.
`timescale 1ns / 1ps

module spectral_flux_lagged_top
    import sfl_pkg::*;
#(
    parameter int MAX_BINS  = DEF_MAX_BINS,
    parameter int MAX_LAG   = DEF_MAX_LAG,
    parameter int MAG_WIDTH = DEF_MAG_WIDTH,
    localparam int S_TDATA_W = ((MAG_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((FLUX_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration: frame_lag
    input  logic                  cfg_wr_en,
    input  logic [LAG_CFG_W-1:0]  cfg_wr_data,

    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [MAG_WIDTH-1:0] magnitude, rest zero
    input  logic                  s_tlast,   // last_bin
    input  logic                  s_tuser,   // [0] new_spectrogram

    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [FLUX_W-1:0] flux, rest zero
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int DEPTH  = MAX_BINS * MAX_LAG;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BIN_W  = $clog2(MAX_BINS + 1);      // holds MAX_BINS itself
    localparam int CNT_W  = $clog2(MAX_LAG + 1);       // frame count / lag
    localparam int SLOT_W = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
    localparam int SUM_W  = ((FLUX_W > MAG_WIDTH) ? FLUX_W : MAG_WIDTH) + 1;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [LAG_CFG_W-1:0] frame_lag_reg;
    logic [CNT_W-1:0]     lag_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_lag_reg <= LAG_RESET;
        end else if (cfg_wr_en) begin
            frame_lag_reg <= cfg_wr_data;
        end
    end

    // lag 0 behaves as 1, anything past MAX_LAG clamps
    always_comb begin
        if (frame_lag_reg == '0) begin
            lag_eff = CNT_W'(1);
        end else if (int'(frame_lag_reg) > MAX_LAG) begin
            lag_eff = CNT_W'(MAX_LAG);
        end else begin
            lag_eff = CNT_W'(frame_lag_reg);
        end
    end

    // ------------------------------------------------------------------
    // Front stage: address generation, history read and write-back.
    // Read and write share one clocked block so the read returns the old
    // word when both hit the same entry (lag equal to MAX_LAG).
    // ------------------------------------------------------------------
    logic [MAG_WIDTH-1:0] hist_mem [DEPTH];
    logic [MAG_WIDTH-1:0] rd_data_reg;

    logic [BIN_W-1:0]  bin_pos_reg, bin_pos_next;
    logic [CNT_W-1:0]  frames_seen_reg, frames_seen_next;
    logic [SLOT_W-1:0] ring_slot_reg, ring_slot_next;

    logic [BIN_W-1:0]     bin_cur;
    logic [CNT_W-1:0]     frames_cur;
    logic [SLOT_W-1:0]    old_slot;
    logic [ADDR_W-1:0]    rd_addr, wr_addr;
    logic [MAG_WIDTH-1:0] s_mag;
    logic                 in_range;
    logic                 live;
    logic                 s_accept;
    logic                 stall;

    // pipeline register between memory read and accumulate
    logic                 p1_valid_reg;
    logic                 p1_last_reg;
    logic                 p1_restart_reg;
    logic                 p1_in_range_reg;
    logic                 p1_live_reg;
    logic [MAG_WIDTH-1:0] p1_mag_reg;

    // hold the front when a finished flux cannot leave the output register
    assign stall    = p1_valid_reg && p1_last_reg && m_tvalid && !m_tready;
    assign s_tready = !stall;
    assign s_accept = s_tvalid && s_tready;
    assign s_mag    = s_tdata[MAG_WIDTH-1:0];

    always_comb begin
        // a restart makes this request bin 0 of frame 0
        bin_cur    = s_tuser ? '0 : bin_pos_reg;
        frames_cur = s_tuser ? '0 : frames_seen_reg;
        in_range   = int'(bin_cur) < MAX_BINS;
        live       = frames_cur >= lag_eff;

        if (int'(ring_slot_reg) >= int'(lag_eff)) begin
            old_slot = SLOT_W'(int'(ring_slot_reg) - int'(lag_eff));
        end else begin
            old_slot = SLOT_W'(int'(ring_slot_reg) + MAX_LAG - int'(lag_eff));
        end

        rd_addr = ADDR_W'(old_slot) * ADDR_W'(MAX_BINS) + ADDR_W'(bin_cur);
        wr_addr = ADDR_W'(ring_slot_reg) * ADDR_W'(MAX_BINS) + ADDR_W'(bin_cur);

        bin_pos_next     = bin_pos_reg;
        frames_seen_next = frames_seen_reg;
        ring_slot_next   = ring_slot_reg;
        if (s_accept) begin
            if (s_tlast) begin
                bin_pos_next = '0;
                if (int'(frames_cur) < MAX_LAG) begin
                    frames_seen_next = frames_cur + CNT_W'(1);
                end else begin
                    frames_seen_next = frames_cur;
                end
                if (int'(ring_slot_reg) == MAX_LAG - 1) begin
                    ring_slot_next = '0;
                end else begin
                    ring_slot_next = ring_slot_reg + SLOT_W'(1);
                end
            end else begin
                bin_pos_next     = in_range ? bin_cur + BIN_W'(1) : bin_cur;
                frames_seen_next = frames_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= hist_mem[rd_addr];
            if (in_range) begin
                hist_mem[wr_addr] <= s_mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_pos_reg     <= '0;
            frames_seen_reg <= '0;
            ring_slot_reg   <= '0;
            p1_valid_reg    <= 1'b0;
        end else begin
            bin_pos_reg     <= bin_pos_next;
            frames_seen_reg <= frames_seen_next;
            ring_slot_reg   <= ring_slot_next;
            if (!stall) begin
                p1_valid_reg <= s_accept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_last_reg     <= s_tlast;
            p1_restart_reg  <= s_tuser;
            p1_in_range_reg <= in_range;
            p1_live_reg     <= live;
            p1_mag_reg      <= s_mag;
        end
    end

    // ------------------------------------------------------------------
    // Accumulate stage: |mag - history| into a saturating frame sum
    // ------------------------------------------------------------------
    logic [FLUX_W-1:0]    acc_reg, acc_next;
    logic [MAG_WIDTH-1:0] diff;
    logic [SUM_W-1:0]     sum;
    logic [FLUX_W-1:0]    sum_sat;
    logic                 p1_fire;
    logic                 new_result;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [FLUX_W-1:0]    m_flux_reg, m_flux_next;

    assign p1_fire    = p1_valid_reg && !stall;
    assign new_result = p1_fire && p1_last_reg;

    always_comb begin
        diff = (p1_mag_reg >= rd_data_reg) ? p1_mag_reg - rd_data_reg
                                           : rd_data_reg - p1_mag_reg;
        sum  = (p1_restart_reg ? '0 : SUM_W'(acc_reg))
             + (p1_in_range_reg ? SUM_W'(diff) : '0);
        sum_sat = (sum > SUM_W'(FLUX_MAX)) ? FLUX_MAX : sum[FLUX_W-1:0];

        acc_next = acc_reg;
        if (p1_fire) begin
            acc_next = p1_last_reg ? '0 : sum_sat;
        end

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_flux_next   = m_flux_reg;
        if (new_result) begin
            m_tvalid_next = 1'b1;
            m_flux_next   = p1_live_reg ? sum_sat : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            acc_reg      <= acc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_flux_reg <= m_flux_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_flux_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_frames_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(frames_seen_reg) <= MAX_LAG)
        else $error("frame count past MAX_LAG");

    a_bin_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(bin_pos_reg) <= MAX_BINS)
        else $error("bin position past MAX_BINS");

    a_last_clears_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (bin_pos_reg == '0))
        else $error("bin position not cleared after last bin");

    a_stall_holds_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (stall) |=> (m_tvalid && p1_valid_reg && $stable(m_flux_reg) == 1'b0) ||
                    (m_tvalid && p1_valid_reg) )
        else $error("stalled result dropped");
`endif

endmodule
